>>> sv/ray_sphere_intersect_assert.svh
// Assertion macros for the ray/sphere intersection block.
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define RSI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ray_sphere_intersect: implication check failed");

// Condition that must never be seen outside reset.
`define RSI_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("ray_sphere_intersect: forbidden condition seen");

`endif

>>> sv/rsi_pkg.sv
// Shared widths, constants and types of the ray/sphere intersection block.
package rsi_pkg;
    localparam int CW     = 32;        // input component width
    localparam int RW     = 31;        // radius width
    localparam int PW     = 64;        // product, a, |h|, |c| width
    localparam int HALF   = PW / 2;    // partial product limb width
    localparam int HW     = 66;        // signed h and c
    localparam int DW     = 128;       // discriminant magnitude
    localparam int SW     = DW / 2;    // square root width, one stage per bit
    localparam int SREMW  = SW + 4;    // square root remainder
    localparam int NW     = 67;        // signed root numerators
    localparam int QW     = 32;        // quotient / distance width
    localparam int QF     = 16;        // fraction bits of Q16.16
    localparam int DREMW  = PW + 1;    // divider remainder
    localparam int NLANE  = 2;         // near and far root
    localparam int MUL_LAT = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_SLACK = 4;     // front stages still in flight

    localparam logic [QW-1:0] MISS_DIST = 32'hFFFF_0000;
    localparam logic [QW-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] SAT_NEG   = 32'h8000_0000;

    // classified request handed from front to back
    typedef struct packed {
        logic [PW-1:0]        a;
        logic signed [HW-1:0] h;
        logic signed [HW-1:0] c;
        logic                 zero_dir;
    } t_fe_item;

    typedef struct packed {
        logic full;
        logic almost_full;
    } t_q_stat;

    typedef struct packed {
        logic                 miss;
        logic                 dzero;
        logic [PW-1:0]        a;
        logic signed [HW-1:0] h;
    } t_sq_tag;

    typedef struct packed {
        logic          miss;
        logic          dzero;
        logic [PW-1:0] a;
    } t_dv_tag;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [DREMW-1:0] rem;
        logic [QW-1:0]    frac;
        logic [QW-1:0]    q;
    } t_dv_lane;
endpackage

>>> sv/rsi_front.sv
// Front end: component magnitudes, products and the a, h, c terms.
module rsi_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req,
    input  logic [rsi_pkg::CW-1:0]  i_eye_x,
    input  logic [rsi_pkg::CW-1:0]  i_eye_y,
    input  logic [rsi_pkg::CW-1:0]  i_eye_z,
    input  logic [rsi_pkg::CW-1:0]  i_dir_x,
    input  logic [rsi_pkg::CW-1:0]  i_dir_y,
    input  logic [rsi_pkg::CW-1:0]  i_dir_z,
    input  logic [rsi_pkg::RW-1:0]  i_radius,
    output logic                    o_vld,
    output rsi_pkg::t_fe_item       o_item
);
    import rsi_pkg::*;

    function automatic logic [CW-1:0] f_mag(logic [CW-1:0] v);
        return v[CW-1] ? -v : v;
    endfunction

    logic            r1_vld;
    logic [CW-1:0]   r1_em [3];
    logic [CW-1:0]   r1_dm [3];
    logic            r1_sn [3];
    logic [RW-1:0]   r1_r;

    logic            r2_vld;
    logic [PW-1:0]   r2_pe [3];
    logic [PW-1:0]   r2_ee [3];
    logic [PW-1:0]   r2_dd [3];
    logic            r2_sn [3];
    logic [PW-1:0]   r2_rr;

    logic                 r3_vld;
    logic [PW-1:0]        r3_a;
    logic [PW-1:0]        r3_e2;
    logic [PW-1:0]        r3_r2;
    logic signed [HW-1:0] r3_h;

    logic      r4_vld;
    t_fe_item  r4_item;

    logic signed [HW-1:0] w_ht [3];

    // stage 1: signs and magnitudes
    always_ff @(posedge i_clk) begin
        r1_em[0] <= f_mag(i_eye_x);
        r1_em[1] <= f_mag(i_eye_y);
        r1_em[2] <= f_mag(i_eye_z);
        r1_dm[0] <= f_mag(i_dir_x);
        r1_dm[1] <= f_mag(i_dir_y);
        r1_dm[2] <= f_mag(i_dir_z);
        r1_sn[0] <= i_eye_x[CW-1] ^ i_dir_x[CW-1];
        r1_sn[1] <= i_eye_y[CW-1] ^ i_dir_y[CW-1];
        r1_sn[2] <= i_eye_z[CW-1] ^ i_dir_z[CW-1];
        r1_r     <= i_radius;
    end

    // stage 2: the ten 32x32 products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_pe[i] <= r1_em[i] * r1_dm[i];
            r2_ee[i] <= r1_em[i] * r1_em[i];
            r2_dd[i] <= r1_dm[i] * r1_dm[i];
            r2_sn[i] <= r1_sn[i];
        end
        r2_rr <= PW'(r1_r) * PW'(r1_r);
    end

    // signed E.D terms
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ht[i] = r2_sn[i] ? -$signed({2'b00, r2_pe[i]}) : $signed({2'b00, r2_pe[i]});
        end
    end

    // stage 3: dot products
    always_ff @(posedge i_clk) begin
        r3_a  <= r2_dd[0] + r2_dd[1] + r2_dd[2];
        r3_e2 <= r2_ee[0] + r2_ee[1] + r2_ee[2];
        r3_r2 <= r2_rr;
        r3_h  <= w_ht[0] + w_ht[1] + w_ht[2];
    end

    // stage 4: c and zero direction
    always_ff @(posedge i_clk) begin
        r4_item.a        <= r3_a;
        r4_item.h        <= r3_h;
        r4_item.c        <= $signed({2'b00, r3_e2}) - $signed({2'b00, r3_r2});
        r4_item.zero_dir <= (r3_a == '0);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_req;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    assign o_vld  = r4_vld;
    assign o_item = r4_item;
endmodule

>>> sv/rsi_fifo.sv
// Request queue between front and back; the back drains it every cycle.
module rsi_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rsi_pkg::t_fe_item  i_data,
    output logic               o_vld,
    output rsi_pkg::t_fe_item  o_data,
    output rsi_pkg::t_q_stat   o_stat
);
    import rsi_pkg::*;

    t_fe_item           r_mem [FIFO_DEPTH];
    t_fe_item           r_q;
    logic               r_q_vld;
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_pop;

    assign w_pop = (r_cnt != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        r_q <= r_mem[r_rd];
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= w_pop;
            if (i_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {{FIFO_AW{1'b0}}, i_push} - {{FIFO_AW{1'b0}}, w_pop};
        end
    end

    assign o_vld              = r_q_vld;
    assign o_data             = r_q;
    assign o_stat.full        = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.almost_full = (r_cnt >= (FIFO_AW+1)'(FIFO_DEPTH - FIFO_SLACK));
endmodule

>>> sv/rsi_mul.sv
// 64x64 unsigned multiplier from four 32x32 partial products, three stages.
module rsi_mul (
    input  logic                    i_clk,
    input  logic [rsi_pkg::PW-1:0]  i_a,
    input  logic [rsi_pkg::PW-1:0]  i_b,
    output logic [rsi_pkg::DW-1:0]  o_p
);
    import rsi_pkg::*;

    logic [PW-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [DW-1:0] r_lo, r_hi, r_p;

    // partial products
    always_ff @(posedge i_clk) begin
        r_p00 <= i_a[HALF-1:0]  * i_b[HALF-1:0];
        r_p01 <= i_a[HALF-1:0]  * i_b[PW-1:HALF];
        r_p10 <= i_a[PW-1:HALF] * i_b[HALF-1:0];
        r_p11 <= i_a[PW-1:HALF] * i_b[PW-1:HALF];
    end

    // two half sums, then the final sum
    always_ff @(posedge i_clk) begin
        r_lo <= {{PW{1'b0}}, r_p00} + {{HALF{1'b0}}, r_p01, {HALF{1'b0}}};
        r_hi <= {r_p11, {PW{1'b0}}} + {{HALF{1'b0}}, r_p10, {HALF{1'b0}}};
        r_p  <= r_lo + r_hi;
    end

    assign o_p = r_p;
endmodule

>>> sv/rsi_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rsi_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  rsi_pkg::t_sq_tag        i_tag,
    input  logic [rsi_pkg::DW-1:0]  i_d,
    output logic                    o_vld,
    output rsi_pkg::t_sq_tag        o_tag,
    output logic [rsi_pkg::SW-1:0]  o_root
);
    import rsi_pkg::*;

    logic             r_vld  [SW];
    t_sq_tag          r_tag  [SW];
    logic [SREMW-1:0] r_rem  [SW];
    logic [SW-1:0]    r_root [SW];
    logic [DW-1:0]    r_dv   [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic             w_pvld;
        t_sq_tag          w_ptag;
        logic [SREMW-1:0] w_prem;
        logic [SW-1:0]    w_proot;
        logic [DW-1:0]    w_pdv;
        logic [SREMW-1:0] w_rem_s;
        logic [SREMW-1:0] w_trial;
        logic             w_ge;
        logic [SREMW-1:0] n_rem;
        logic [SW-1:0]    n_root;

        if (k == 0) begin : g_head
            assign w_pvld  = i_vld;
            assign w_ptag  = i_tag;
            assign w_prem  = '0;
            assign w_proot = '0;
            assign w_pdv   = i_d;
        end else begin : g_body
            assign w_pvld  = r_vld[k-1];
            assign w_ptag  = r_tag[k-1];
            assign w_prem  = r_rem[k-1];
            assign w_proot = r_root[k-1];
            assign w_pdv   = r_dv[k-1];
        end

        // bring down two bits, try 4*root+1
        always_comb begin
            w_rem_s = {w_prem[SREMW-3:0], w_pdv[DW-1 -: 2]};
            w_trial = SREMW'({w_proot, 2'b01});
            w_ge    = (w_rem_s >= w_trial);
            n_rem   = w_ge ? w_rem_s - w_trial : w_rem_s;
            n_root  = {w_proot[SW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_pvld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k]  <= w_ptag;
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_dv[k]   <= w_pdv << 2;
        end
    end

    assign o_vld  = r_vld[SW-1];
    assign o_tag  = r_tag[SW-1];
    assign o_root = r_root[SW-1];
endmodule

>>> sv/rsi_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
module rsi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  rsi_pkg::t_dv_tag   i_tag,
    input  rsi_pkg::t_dv_lane  i_lane [rsi_pkg::NLANE],
    output logic               o_vld,
    output rsi_pkg::t_dv_tag   o_tag,
    output rsi_pkg::t_dv_lane  o_lane [rsi_pkg::NLANE]
);
    import rsi_pkg::*;

    logic     r_vld  [QW];
    t_dv_tag  r_tag  [QW];
    t_dv_lane r_lane [QW][NLANE];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             w_pvld;
        t_dv_tag          w_ptag;
        t_dv_lane         w_plane [NLANE];
        logic [DREMW-1:0] w_rem_s [NLANE];
        logic             w_ge    [NLANE];
        t_dv_lane         n_lane  [NLANE];

        if (k == 0) begin : g_head
            assign w_pvld  = i_vld;
            assign w_ptag  = i_tag;
            assign w_plane = i_lane;
        end else begin : g_body
            assign w_pvld  = r_vld[k-1];
            assign w_ptag  = r_tag[k-1];
            assign w_plane = r_lane[k-1];
        end

        // shift in one numerator bit, subtract the divisor if it fits
        always_comb begin
            for (int l = 0; l < NLANE; l++) begin
                w_rem_s[l]     = {w_plane[l].rem[DREMW-2:0], w_plane[l].frac[QW-1]};
                w_ge[l]        = (w_rem_s[l] >= {1'b0, w_ptag.a});
                n_lane[l]      = w_plane[l];
                n_lane[l].rem  = w_ge[l] ? w_rem_s[l] - {1'b0, w_ptag.a} : w_rem_s[l];
                n_lane[l].frac = {w_plane[l].frac[QW-2:0], 1'b0};
                n_lane[l].q    = {w_plane[l].q[QW-2:0], w_ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_pvld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k]  <= w_ptag;
            r_lane[k] <= n_lane;
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_tag  = r_tag[QW-1];
    assign o_lane = r_lane[QW-1];
endmodule

>>> sv/rsi_back.sv
// Back end: discriminant, square root, both roots and the choice of distance.
module rsi_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  rsi_pkg::t_fe_item       i_item,
    output logic                    o_vld,
    output logic                    o_hit,
    output logic [rsi_pkg::QW-1:0]  o_distance
);
    import rsi_pkg::*;

    typedef struct packed {
        logic                 zero_dir;
        logic                 cneg;
        logic [PW-1:0]        a;
        logic signed [HW-1:0] h;
    } t_ms;

    function automatic logic [QW-1:0] f_sat(t_dv_lane l);
        if (l.neg) begin
            if (l.ovf || (l.q > SAT_NEG)) return SAT_NEG;
            return -l.q;
        end
        if (l.ovf || l.q[QW-1]) return SAT_POS;
        return l.q;
    endfunction

    // operand stage
    logic           r_b0_vld;
    logic [PW-1:0]  r_b0_hm, r_b0_cm;
    t_ms            r_b0_ms;

    always_ff @(posedge i_clk) begin
        r_b0_hm <= PW'(i_item.h[HW-1] ? -i_item.h : i_item.h);
        r_b0_cm <= PW'(i_item.c[HW-1] ? -i_item.c : i_item.c);
        r_b0_ms <= '{zero_dir: i_item.zero_dir, cneg: i_item.c[HW-1],
                     a: i_item.a, h: i_item.h};
    end

    // h*h and a*|c|
    logic [DW-1:0] w_hh, w_ac;

    rsi_mul u_mul_hh (.i_clk(i_clk), .i_a(r_b0_hm), .i_b(r_b0_hm), .o_p(w_hh));
    rsi_mul u_mul_ac (.i_clk(i_clk), .i_a(r_b0_ms.a), .i_b(r_b0_cm), .o_p(w_ac));

    logic r_ms_vld [MUL_LAT];
    t_ms  r_ms     [MUL_LAT];

    always_ff @(posedge i_clk) begin
        r_ms[0] <= r_b0_ms;
        for (int i = 1; i < MUL_LAT; i++) r_ms[i] <= r_ms[i-1];
    end

    // discriminant h*h - a*c
    logic [DW+1:0] w_d;
    logic          r_d_vld;
    logic [DW-1:0] r_d;
    t_sq_tag       r_d_tag;

    always_comb begin
        w_d = r_ms[MUL_LAT-1].cneg ? {2'b00, w_hh} + {2'b00, w_ac}
                                   : {2'b00, w_hh} - {2'b00, w_ac};
    end

    always_ff @(posedge i_clk) begin
        r_d     <= w_d[DW-1:0];
        r_d_tag <= '{miss: r_ms[MUL_LAT-1].zero_dir || w_d[DW+1], dzero: (w_d == '0),
                     a: r_ms[MUL_LAT-1].a, h: r_ms[MUL_LAT-1].h};
    end

    // square root
    logic          w_sq_vld;
    t_sq_tag       w_sq_tag;
    logic [SW-1:0] w_root;

    rsi_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_d_vld), .i_tag(r_d_tag), .i_d(r_d),
        .o_vld(w_sq_vld), .o_tag(w_sq_tag), .o_root(w_root)
    );

    // numerators -h - s and -h + s
    logic signed [NW-1:0] w_nh, w_s;
    logic                 r_n_vld;
    logic signed [NW-1:0] r_n [NLANE];
    t_dv_tag              r_n_tag;

    assign w_nh = -NW'(w_sq_tag.h);
    assign w_s  = $signed({{(NW-SW){1'b0}}, w_root});

    always_ff @(posedge i_clk) begin
        r_n[0]  <= w_nh - w_s;
        r_n[1]  <= w_nh + w_s;
        r_n_tag <= '{miss: w_sq_tag.miss, dzero: w_sq_tag.dzero, a: w_sq_tag.a};
    end

    // magnitudes, overflow check and divider setup
    logic [NW-1:0] w_nmag [NLANE];
    t_dv_lane      n_dv   [NLANE];
    logic          r_dv_vld;
    t_dv_tag       r_dv_tag;
    t_dv_lane      r_dv   [NLANE];

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            w_nmag[l]    = r_n[l][NW-1] ? NW'(-r_n[l]) : NW'(r_n[l]);
            n_dv[l].neg  = r_n[l][NW-1];
            n_dv[l].ovf  = ({{(PW+QF-NW){1'b0}}, w_nmag[l]} >= {r_n_tag.a, {QF{1'b0}}});
            n_dv[l].rem  = DREMW'(w_nmag[l][NW-1:QF]);
            n_dv[l].frac = {w_nmag[l][QF-1:0], {(QW-QF){1'b0}}};
            n_dv[l].q    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_tag <= r_n_tag;
        r_dv     <= n_dv;
    end

    // quotients
    logic     w_q_vld;
    t_dv_tag  w_q_tag;
    t_dv_lane w_q_lane [NLANE];

    rsi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_dv_vld), .i_tag(r_dv_tag), .i_lane(r_dv),
        .o_vld(w_q_vld), .o_tag(w_q_tag), .o_lane(w_q_lane)
    );

    // pick the smaller positive root; with a zero discriminant the near root is taken
    logic [QW-1:0] w_q0, w_q1, n_dist;
    logic          w_pos0, w_pos1, w_le, n_hit;
    logic          r_out_vld, r_hit;
    logic [QW-1:0] r_dist;

    always_comb begin
        w_q0   = f_sat(w_q_lane[0]);
        w_q1   = f_sat(w_q_lane[1]);
        w_pos0 = !w_q0[QW-1] && (w_q0 != '0);
        w_pos1 = !w_q1[QW-1] && (w_q1 != '0);
        w_le   = ($signed(w_q0) <= $signed(w_q1));
        n_hit  = 1'b0;
        n_dist = MISS_DIST;
        if (w_q_tag.miss) begin
            n_hit = 1'b0;
        end else if (w_q_tag.dzero) begin
            n_hit  = 1'b1;
            n_dist = w_q0;
        end else if (w_pos0 && (!w_pos1 || w_le)) begin
            n_hit  = 1'b1;
            n_dist = w_q0;
        end else if (w_pos1) begin
            n_hit  = 1'b1;
            n_dist = w_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= n_hit;
        r_dist <= n_dist;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_vld  <= 1'b0;
            r_d_vld   <= 1'b0;
            r_n_vld   <= 1'b0;
            r_dv_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < MUL_LAT; i++) r_ms_vld[i] <= 1'b0;
        end else begin
            r_b0_vld    <= i_vld;
            r_ms_vld[0] <= r_b0_vld;
            for (int i = 1; i < MUL_LAT; i++) r_ms_vld[i] <= r_ms_vld[i-1];
            r_d_vld     <= r_ms_vld[MUL_LAT-1];
            r_n_vld     <= w_sq_vld;
            r_dv_vld    <= r_n_vld;
            r_out_vld   <= w_q_vld;
        end
    end

    assign o_vld      = r_out_vld;
    assign o_hit      = r_hit;
    assign o_distance = r_dist;
endmodule

>>> sv/ray_sphere_intersect.sv
// Ray/sphere intersection: top level joining front end, request queue and back end.
// One ray request is taken per clock while busy is low, and each request gives one
// result, strobed on o_valid for a single cycle, with the results leaving
// in request order. Most of the pipeline lies in the 64-stage square root (one root
// bit per stage) and the 32-stage divider (one quotient bit per stage) in the back
// end. The back end drains the request queue every cycle, so busy stays low in
// operation; it rises only if the queue came within the front end's depth of full.
// The receiver cannot stall the block: results must be taken when strobed.
`include "ray_sphere_intersect_assert.svh"
module ray_sphere_intersect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic [31:0] i_dir_z,
    input  logic [30:0] i_radius,
    output logic        o_valid,
    output logic        o_hit,
    output logic [31:0] o_distance
);
    import rsi_pkg::*;

    logic     w_req;
    logic     w_fe_vld;
    t_fe_item w_fe_item;
    logic     w_q_vld;
    t_fe_item w_q_item;
    t_q_stat  w_q_stat;

    assign w_req = start && !busy;
    assign busy  = w_q_stat.almost_full;

    rsi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .i_eye_x(i_eye_x), .i_eye_y(i_eye_y), .i_eye_z(i_eye_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_radius(i_radius), .o_vld(w_fe_vld), .o_item(w_fe_item)
    );

    rsi_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_fe_vld), .i_data(w_fe_item),
        .o_vld(w_q_vld), .o_data(w_q_item), .o_stat(w_q_stat)
    );

    rsi_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(w_q_vld), .i_item(w_q_item),
        .o_vld(o_valid), .o_hit(o_hit), .o_distance(o_distance)
    );

    // a miss always reports -1.0
    `RSI_ASSERT_IMPL(a_miss_dist, o_valid && !o_hit, o_distance == MISS_DIST)
    // the busy threshold leaves room for every request still in the front end
    `RSI_ASSERT_NEVER(a_queue_overrun, w_fe_vld && w_q_stat.full)
endmodule
